### design/lppbh_pkg.sv
// Shared types and constants for the laser point projection and box hit block.
package lppbh_pkg;

  // Item kinds carried on the input tuser field.
  localparam logic [1:0] ACT_CLEAR = 2'd0;
  localparam logic [1:0] ACT_LOAD  = 2'd1;
  localparam logic [1:0] ACT_PROJ  = 2'd2;
  localparam logic [1:0] ACT_SPARE = 2'd3;  // unused kind, ignored

  // Configuration register indexes.
  localparam logic [2:0] REG_ROT_X = 3'd0;
  localparam logic [2:0] REG_ROT_Y = 3'd1;
  localparam logic [2:0] REG_ROT_Z = 3'd2;
  localparam logic [2:0] REG_FOCAL = 3'd3;
  localparam logic [2:0] REG_CENTRE = 3'd4;

  // Datapath widths.
  localparam int CAM_W = 34;   // camera coordinate, mm Q.14
  localparam int NUM_W = 59;   // focal times camera coordinate
  localparam int ZMAG_W = 33;  // magnitude of a positive depth
  localparam int Q_W = 26;     // quotient bits kept before clamping
  localparam int REM_W = ZMAG_W + Q_W;
  localparam int UQ_W = 29;    // pixel in Q.8, signed
  localparam int HIT_W = 8;

  // Item kind and box geometry, carried alongside each word.
  typedef struct packed {
    logic [1:0]  action;
    logic [11:0] cu;
    logic [11:0] cv;
    logic [11:0] w;
    logic [11:0] h;
  } item_ctl_t;

  // One detection box held in the table.
  typedef struct packed {
    logic [11:0] cu;
    logic [11:0] cv;
    logic [11:0] w;
    logic [11:0] h;
  } box_t;

endpackage

### design/lidar_point_projection_box_hit.sv
// Pipelined laser point to camera pixel projector with detection box hit mask.
//
//  Channel | Direction | Contents
//  in_     | slave     | tuser: action; tdata: point x, y, z, box cu, cv, w, h
//  out_    | master    | tuser: in_front; tdata: pixel u, pixel v, box hits
//  cfg_    | write     | register index and data, no read-back
//
// One word is accepted every cycle while the output is not held; a result is
// presented through 32 register stages: the 26 restoring divider steps plus
// six other stages.
// Reset is synchronous and clears the valid bits, the box count and the
// configuration registers. When the output word is not taken the whole
// pipeline holds, and in_tready falls in the same cycle.
module lidar_point_projection_box_hit
  import lppbh_pkg::*;
#(
  parameter int MAX_BOXES = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // action
  input  logic [95:0] in_tdata,   // point_x, point_y, point_z, box_center_u,
                                  // box_center_v, box_width, box_height
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic        out_tuser,  // in_front
  output logic [39:0] out_tdata,  // pixel_u, pixel_v, box_hits
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_wdata
);

  localparam int CNT_W = $clog2(MAX_BOXES + 1);
  localparam int IDX_W = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int HIT_N = (MAX_BOXES < HIT_W) ? MAX_BOXES : HIT_W;
  localparam int DIV_STEPS = Q_W;

  logic en;

  // Configuration registers.
  logic [63:0] rot_r [0:2];
  logic [47:0] focal_r;
  logic [47:0] centre_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_r[0] <= '0;
      rot_r[1] <= '0;
      rot_r[2] <= '0;
      focal_r <= '0;
      centre_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_ROT_X:  rot_r[0] <= cfg_wdata;
        REG_ROT_Y:  rot_r[1] <= cfg_wdata;
        REG_ROT_Z:  rot_r[2] <= cfg_wdata;
        REG_FOCAL:  focal_r <= cfg_wdata[47:0];
        REG_CENTRE: centre_r <= cfg_wdata[47:0];
        default: ;
      endcase
    end
  end

  // The whole pipeline advances unless the output word is held.
  logic out_valid_r;
  assign en = !out_valid_r || out_tready;
  assign in_tready = en;

  item_ctl_t in_ctl;
  logic signed [15:0] pt [0:2];
  assign pt[0] = $signed(in_tdata[15:0]);
  assign pt[1] = $signed(in_tdata[31:16]);
  assign pt[2] = $signed(in_tdata[47:32]);
  assign in_ctl.action = in_tuser;
  assign in_ctl.cu = in_tdata[59:48];
  assign in_ctl.cv = in_tdata[71:60];
  assign in_ctl.w = in_tdata[83:72];
  assign in_ctl.h = in_tdata[95:84];

  // Stage 1: nine rotation products and the scaled translations.
  logic               v1_r;
  item_ctl_t          ctl1_r;
  logic signed [31:0] prod1_r [0:2][0:2];
  logic signed [29:0] tr1_r [0:2];

  always_ff @(posedge clk) begin
    if (en) begin
      ctl1_r <= in_ctl;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod1_r[r][c] <= 32'($signed(rot_r[r][16*c +: 16])) * 32'(pt[c]);
        end
        tr1_r[r] <= {$signed(rot_r[r][63:48]), 14'b0};
      end
    end
  end

  // Stage 2: camera frame coordinates.
  logic                    v2_r;
  item_ctl_t               ctl2_r;
  logic signed [CAM_W-1:0] cam2_r [0:2];

  always_ff @(posedge clk) begin
    if (en) begin
      ctl2_r <= ctl1_r;
      for (int r = 0; r < 3; r++) begin
        cam2_r[r] <= CAM_W'(prod1_r[r][0]) + CAM_W'(prod1_r[r][1])
                   + CAM_W'(prod1_r[r][2]) + CAM_W'(tr1_r[r]);
      end
    end
  end

  // Stage 3: scale x and y by the focal lengths.
  logic                    v3_r;
  item_ctl_t               ctl3_r;
  logic signed [NUM_W-1:0] num3_r [0:1];
  logic signed [CAM_W-1:0] z3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      ctl3_r <= ctl2_r;
      z3_r <= cam2_r[2];
      num3_r[0] <= NUM_W'($signed({1'b0, focal_r[23:0]})) * NUM_W'(cam2_r[0]);
      num3_r[1] <= NUM_W'($signed({1'b0, focal_r[47:24]})) * NUM_W'(cam2_r[1]);
    end
  end

  // Stage 4 onwards: sign-magnitude restoring division, one quotient bit a
  // stage. A quotient beyond Q_W bits is flagged; such a pixel saturates.
  logic                dv_r    [0:DIV_STEPS];
  item_ctl_t           dctl_r  [0:DIV_STEPS];
  logic                front_r [0:DIV_STEPS];
  logic [ZMAG_W-1:0]   zmag_r  [0:DIV_STEPS];
  logic [REM_W-1:0]    rem_r   [0:DIV_STEPS][0:1];
  logic [Q_W-1:0]      quo_r   [0:DIV_STEPS][0:1];
  logic                neg_r   [0:DIV_STEPS][0:1];
  logic                ovf_r   [0:DIV_STEPS][0:1];

  always_ff @(posedge clk) begin
    if (en) begin
      dctl_r[0] <= ctl3_r;
      front_r[0] <= (z3_r > 0);
      zmag_r[0] <= z3_r[ZMAG_W-1:0];
      for (int l = 0; l < 2; l++) begin
        neg_r[0][l] <= num3_r[l][NUM_W-1];
        rem_r[0][l] <= num3_r[l][NUM_W-1] ? REM_W'(-num3_r[l]) : REM_W'(num3_r[l]);
        ovf_r[0][l] <= (num3_r[l][NUM_W-1] ? REM_W'(-num3_r[l]) : REM_W'(num3_r[l]))
                       >= {z3_r[ZMAG_W-1:0], {Q_W{1'b0}}};
        quo_r[0][l] <= '0;
      end
    end
  end

  for (genvar j = 1; j <= DIV_STEPS; j++) begin : g_div
    localparam int K = DIV_STEPS - j;
    logic [REM_W-1:0] trial;
    assign trial = REM_W'(zmag_r[j-1]) << K;

    always_ff @(posedge clk) begin
      if (en) begin
        dctl_r[j] <= dctl_r[j-1];
        front_r[j] <= front_r[j-1];
        zmag_r[j] <= zmag_r[j-1];
        for (int l = 0; l < 2; l++) begin
          neg_r[j][l] <= neg_r[j-1][l];
          ovf_r[j][l] <= ovf_r[j-1][l];
          if (rem_r[j-1][l] >= trial) begin
            rem_r[j][l] <= rem_r[j-1][l] - trial;
            quo_r[j][l] <= quo_r[j-1][l] | (Q_W'(1) << K);
          end else begin
            rem_r[j][l] <= rem_r[j-1][l];
            quo_r[j][l] <= quo_r[j-1][l];
          end
        end
      end
    end
  end

  // Final stage before output: floor rounding, clamping and centre offset.
  logic                   v5_r;
  item_ctl_t              ctl5_r;
  logic                   front5_r;
  logic signed [UQ_W-1:0] uq5_r [0:1];
  logic signed [UQ_W-1:0] uq_nxt [0:1];

  always_comb begin
    logic [Q_W:0]        mag;
    logic signed [Q_W+1:0] qs;
    for (int l = 0; l < 2; l++) begin
      mag = ovf_r[DIV_STEPS][l] ? (Q_W+1)'(1) << Q_W : {1'b0, quo_r[DIV_STEPS][l]};
      if (neg_r[DIV_STEPS][l]) begin
        qs = -$signed({1'b0, mag}) -
             ((!ovf_r[DIV_STEPS][l] && rem_r[DIV_STEPS][l] != '0) ? (Q_W+2)'(1)
                                                                  : (Q_W+2)'(0));
      end else begin
        qs = $signed({1'b0, mag});
      end
      uq_nxt[l] = UQ_W'(qs) + $signed(UQ_W'(centre_r[24*l +: 24]));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl5_r <= dctl_r[DIV_STEPS];
      front5_r <= front_r[DIV_STEPS];
      uq5_r[0] <= uq_nxt[0];
      uq5_r[1] <= uq_nxt[1];
    end
  end

  // Valid bits travel with the words.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      for (int j = 0; j <= DIV_STEPS; j++) dv_r[j] <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_tvalid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      dv_r[0] <= v3_r;
      for (int j = 1; j <= DIV_STEPS; j++) dv_r[j] <= dv_r[j-1];
      v5_r <= dv_r[DIV_STEPS];
    end
  end

  // Box table: updated in this last stage so that earlier points see the
  // table as it stood when they were accepted.
  box_t             box_r [0:MAX_BOXES-1];
  logic [CNT_W-1:0] count_r;
  logic             tbl_go;
  assign tbl_go = en && v5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (tbl_go) begin
      if (ctl5_r.action == ACT_CLEAR) begin
        count_r <= '0;
      end else if (ctl5_r.action == ACT_LOAD && count_r < CNT_W'(MAX_BOXES)) begin
        count_r <= count_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tbl_go && ctl5_r.action == ACT_LOAD && count_r < CNT_W'(MAX_BOXES)) begin
      box_r[count_r[IDX_W-1:0]] <= '{cu: ctl5_r.cu, cv: ctl5_r.cv,
                                     w: ctl5_r.w, h: ctl5_r.h};
    end
  end

  // Hit test against every loaded box, up to HIT_W of them, in parallel.
  logic [HIT_W-1:0] hits;

  function automatic logic within_box(input logic signed [UQ_W-1:0] q8,
                                      input logic [11:0] centre,
                                      input logic [11:0] size);
    logic signed [UQ_W:0] d;
    logic [UQ_W:0]        ad;
    d = (UQ_W+1)'(q8) - (UQ_W+1)'($signed({1'b0, centre, 8'b0}));
    ad = d[UQ_W] ? (UQ_W+1)'(-d) : (UQ_W+1)'(d);
    return {ad, 1'b0} < (UQ_W+2)'({size, 8'b0});
  endfunction

  for (genvar i = 0; i < HIT_W; i++) begin : g_hit
    if (i < HIT_N) begin : g_on
      assign hits[i] = (CNT_W'(i) < count_r)
                       && within_box(uq5_r[0], box_r[i].cu, box_r[i].w)
                       && within_box(uq5_r[1], box_r[i].cv, box_r[i].h);
    end else begin : g_off
      assign hits[i] = 1'b0;
    end
  end

  // Round half up to whole pixels and saturate to 16 bits.
  function automatic logic [15:0] to_pixel(input logic signed [UQ_W-1:0] q8);
    logic signed [UQ_W:0]   s;
    logic signed [UQ_W-8:0] p;
    s = (UQ_W+1)'(q8) + (UQ_W+1)'(128);
    p = s[UQ_W:8];
    if (p > (UQ_W-7)'(32767)) return 16'h7FFF;
    else if (p < -(UQ_W-7)'(32768)) return 16'h8000;
    else return p[15:0];
  endfunction

  // Output register.
  logic        out_front_r;
  logic [15:0] out_u_r;
  logic [15:0] out_v_r;
  logic [7:0]  out_hits_r;
  logic        out_valid_nxt;
  assign out_valid_nxt = v5_r && ctl5_r.action == ACT_PROJ;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_front_r <= front5_r;
      out_u_r <= front5_r ? to_pixel(uq5_r[0]) : 16'd0;
      out_v_r <= front5_r ? to_pixel(uq5_r[1]) : 16'd0;
      out_hits_r <= front5_r ? hits : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser = out_front_r;
  assign out_tdata = {out_hits_r, out_v_r, out_u_r};

endmodule

### tb/tb.sv
// Self-checking testbench for the laser point projection and box hit block.
module tb;
  import lppbh_pkg::*;

  localparam int  TABLE_DEPTH = 8;
  localparam int  DRAIN_CYCLES = 45;
  localparam longint CYCLE_LIMIT = 600000;

  // One projected pixel as the block should report it.
  typedef struct {
    logic        in_front;
    logic [15:0] pix_u;
    logic [15:0] pix_v;
    logic [7:0]  hits;
  } pixel_word_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [1:0]  in_tuser;
  logic [95:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic        out_tuser;
  logic [39:0] out_tdata;
  logic        cfg_wr_en;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_wdata;

  // Shadow copy of the configuration and the box table.
  logic [63:0] sh_rot_x, sh_rot_y, sh_rot_z;
  logic [47:0] sh_focal, sh_centre;
  box_t        sh_boxes [TABLE_DEPTH];
  int          sh_box_count;

  pixel_word_t pixel_q [$];
  int          fail_cnt;
  int          words_sent;
  int          words_checked;
  int          behind_cnt;
  int          hit_cnt;
  longint      cycle_cnt;
  bit          quiet_mode;
  int          hold_req;

  lidar_point_projection_box_hit u_top (.*);

  // Clock.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_cnt);
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic longint sx16(logic [15:0] v);
    longint r;
    r = $signed(v);
    return r;
  endfunction

  function automatic longint row_dot(logic [63:0] row, longint x, longint y, longint z);
    return sx16(row[15:0]) * x + sx16(row[31:16]) * y + sx16(row[47:32]) * z
         + sx16(row[63:48]) * 16384;
  endfunction

  function automatic longint floor_div(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q = q - 1;
    return q;
  endfunction

  function automatic logic [15:0] whole_pixel(longint q8);
    longint p;
    p = (q8 + 128) >>> 8;
    if (p > 32767) p = 32767;
    if (p < -32768) p = -32768;
    return p[15:0];
  endfunction

  function automatic bit box_contains(longint q8, logic [11:0] centre, logic [11:0] size);
    longint d;
    d = q8 - longint'(centre) * 256;
    if (d < 0) d = -d;
    return 2 * d < longint'(size) * 256;
  endfunction

  // Projects one laser point with the shadow configuration and box table.
  function automatic pixel_word_t project_point(logic [15:0] px, logic [15:0] py,
                                                logic [15:0] pz);
    pixel_word_t r;
    longint x, y, z, xc, yc, zc, uq, vq;
    x = sx16(px);
    y = sx16(py);
    z = sx16(pz);
    xc = row_dot(sh_rot_x, x, y, z);
    yc = row_dot(sh_rot_y, x, y, z);
    zc = row_dot(sh_rot_z, x, y, z);
    r.in_front = 1'b0;
    r.pix_u = '0;
    r.pix_v = '0;
    r.hits = '0;
    if (zc <= 0) return r;
    uq = floor_div(longint'(sh_focal[23:0]) * xc, zc) + longint'(sh_centre[23:0]);
    vq = floor_div(longint'(sh_focal[47:24]) * yc, zc) + longint'(sh_centre[47:24]);
    r.in_front = 1'b1;
    r.pix_u = whole_pixel(uq);
    r.pix_v = whole_pixel(vq);
    for (int i = 0; i < sh_box_count; i++) begin
      if (box_contains(uq, sh_boxes[i].cu, sh_boxes[i].w) &&
          box_contains(vq, sh_boxes[i].cv, sh_boxes[i].h))
        r.hits[i] = 1'b1;
    end
    return r;
  endfunction

  // Receiver: random stalls per word, long hold-offs on request, and the check.
  int stall_left;
  int hold_left;
  always @(posedge clk) begin
    pixel_word_t e;
    if (!rst_n) begin
      stall_left = 0;
      hold_left = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        words_checked++;
        if (pixel_q.size() == 0) begin
          $error("Result word with no expectation waiting");
          fail_cnt++;
        end else begin
          e = pixel_q.pop_front();
          if (out_tuser !== e.in_front) begin
            $error("in_front: expected %0d, got %0d", e.in_front, out_tuser);
            fail_cnt++;
          end
          if (out_tdata[15:0] !== e.pix_u) begin
            $error("pixel_u: expected %0d, got %0d", $signed(e.pix_u),
                   $signed(out_tdata[15:0]));
            fail_cnt++;
          end
          if (out_tdata[31:16] !== e.pix_v) begin
            $error("pixel_v: expected %0d, got %0d", $signed(e.pix_v),
                   $signed(out_tdata[31:16]));
            fail_cnt++;
          end
          if (out_tdata[39:32] !== e.hits) begin
            $error("box_hits: expected %h, got %h", e.hits, out_tdata[39:32]);
            fail_cnt++;
          end
        end
        stall_left = quiet_mode ? 0 : $urandom_range(0, 15);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left > 0) hold_left--;
    end
    out_tready <= rst_n && stall_left == 0 && hold_left == 0;
  end

  // Writes one configuration register and mirrors it in the shadow copy.
  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_ROT_X:  sh_rot_x = val;
      REG_ROT_Y:  sh_rot_y = val;
      REG_ROT_Z:  sh_rot_z = val;
      REG_FOCAL:  sh_focal = val[47:0];
      REG_CENTRE: sh_centre = val[47:0];
      default: ;
    endcase
  endtask

  // Random bits above bit 47 of the narrow registers must be ignored.
  task automatic write_all(logic [63:0] rx, logic [63:0] ry, logic [63:0] rz,
                           logic [47:0] focal, logic [47:0] centre);
    write_reg(REG_ROT_X, rx);
    write_reg(REG_ROT_Y, ry);
    write_reg(REG_ROT_Z, rz);
    write_reg(REG_FOCAL, {16'($urandom), 48'h0} | 64'(focal));
    write_reg(REG_CENTRE, {16'($urandom), 48'h0} | 64'(centre));
  endtask

  // Sends one word and updates the prediction when it is accepted.
  task automatic send_word(logic [1:0] act, logic [15:0] px, logic [15:0] py,
                           logic [15:0] pz, logic [11:0] cu, logic [11:0] cv,
                           logic [11:0] w, logic [11:0] h, bit no_gap = 0);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser <= act;
    in_tdata <= {h, w, cv, cu, pz, py, px};
    do @(posedge clk); while (!in_tready);
    words_sent++;
    case (act)
      ACT_CLEAR: sh_box_count = 0;
      ACT_LOAD: begin
        if (sh_box_count < TABLE_DEPTH) begin
          sh_boxes[sh_box_count] = '{cu: cu, cv: cv, w: w, h: h};
          sh_box_count++;
        end
      end
      ACT_PROJ: begin
        pixel_q.insert(pixel_q.size(), project_point(px, py, pz));
        if (pixel_q[$].in_front == 1'b0) behind_cnt++;
        if (pixel_q[$].hits != 0) hit_cnt++;
      end
      default: ;
    endcase
    gap = (quiet_mode || no_gap) ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Lets every expected word arrive, then lets the pipeline empty.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // A camera looking along laser z, offset by tz mm along it, with a plausible lens.
  task automatic camera_setup(int f_px, int tz);
    write_all({16'd0, 16'd0, 16'd0, 16'd16384},
              {16'd0, 16'd0, 16'd16384, 16'd0},
              {16'(tz), 16'd16384, 16'd0, 16'd0},
              {24'(f_px * 256), 24'(f_px * 256)},
              {24'(360 * 256 + 77), 24'(640 * 256 + 128)});
  endtask

  task automatic send_random_word(bit plausible);
    int sel;
    logic [15:0] px, py, pz;
    logic [11:0] cu, cv, w, h;
    sel = $urandom_range(0, 99);
    px = 16'($urandom);
    py = 16'($urandom);
    pz = 16'($urandom);
    cu = 12'($urandom);
    cv = 12'($urandom);
    w = 12'($urandom);
    h = 12'($urandom);
    if (plausible && $urandom_range(0, 9) < 8) begin
      pz = 16'($urandom_range(200, 20000));
      px = $signed(16'($urandom_range(0, 2 * pz))) - $signed(pz);
      py = $signed(16'($urandom_range(0, 2 * pz))) - $signed(pz);
      cu = 12'($urandom_range(0, 1280));
      cv = 12'($urandom_range(0, 720));
      w = 12'($urandom_range(0, 700));
      h = 12'($urandom_range(0, 500));
    end
    if (sel < 4) send_word(ACT_CLEAR, px, py, pz, cu, cv, w, h);
    else if (sel < 18) send_word(ACT_LOAD, px, py, pz, cu, cv, w, h);
    else if (sel < 96) send_word(ACT_PROJ, px, py, pz, cu, cv, w, h);
    else send_word(ACT_SPARE, px, py, pz, cu, cv, w, h);
  endtask

  // Field extremes, every action, the full table, boxes of zero size,
  // points behind the camera and saturated pixels.
  task automatic test_directed();
    camera_setup(800, 1000);
    send_word(ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0);
    send_word(ACT_PROJ, 0, 0, 1000, 0, 0, 0, 0);
    send_word(ACT_LOAD, 0, 0, 0, 640, 360, 0, 0);
    send_word(ACT_LOAD, 0, 0, 0, 640, 360, 4, 4);
    send_word(ACT_LOAD, 0, 0, 0, 4095, 4095, 4095, 4095);
    send_word(ACT_LOAD, 0, 0, 0, 0, 0, 4095, 4095);
    send_word(ACT_LOAD, 0, 0, 0, 700, 400, 200, 200);
    send_word(ACT_LOAD, 0, 0, 0, 640, 360, 1, 1);
    send_word(ACT_LOAD, 0, 0, 0, 100, 100, 50, 50);
    send_word(ACT_LOAD, 0, 0, 0, 640, 360, 3000, 3000);
    // Table is full: this box must be dropped.
    send_word(ACT_LOAD, 0, 0, 0, 640, 360, 2000, 2000);
    send_word(ACT_PROJ, 0, 0, 1000, 0, 0, 0, 0);
    send_word(ACT_PROJ, 100, 50, 2000, 0, 0, 0, 0);
    send_word(ACT_PROJ, 16'h7fff, 16'h7fff, 16'h7fff, 12'hfff, 12'hfff, 12'hfff, 12'hfff);
    send_word(ACT_PROJ, 16'h8000, 16'h8000, 16'h7fff, 0, 0, 0, 0);
    // Depth exactly zero, then below zero.
    send_word(ACT_PROJ, 5, 5, -16'sd1000, 0, 0, 0, 0);
    send_word(ACT_PROJ, 5, 5, 16'h8000, 0, 0, 0, 0);
    // Tiny depth with large offsets drives the pixel to saturation.
    send_word(ACT_PROJ, 16'h7fff, 16'h8000, -16'sd999, 0, 0, 0, 0);
    send_word(ACT_PROJ, 16'h8000, 16'h7fff, -16'sd999, 0, 0, 0, 0);
    send_word(ACT_SPARE, 16'hffff, 16'hffff, 16'hffff, 12'hfff, 12'hfff, 12'hfff, 12'hfff);
    send_word(ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0);
    send_word(ACT_PROJ, 0, 0, 1000, 0, 0, 0, 0);
    drain();
  endtask

  // Register extremes: all zero, all ones and the signed limits, plus
  // writes to unused indexes that must be ignored.
  task automatic test_register_extremes();
    write_all('0, '0, '0, '0, '0);
    for (int i = 0; i < 20; i++) send_random_word(1'b0);
    drain();
    write_all('1, '1, '1, '1, '1);
    for (int i = 0; i < 20; i++) send_random_word(1'b0);
    drain();
    write_all(64'h7fff_8000_7fff_8000, 64'h8000_7fff_8000_7fff,
              64'h7fff_7fff_7fff_7fff, 48'hffffff_ffffff, 48'h000000_ffffff);
    write_reg(3'd5, '1);
    write_reg(3'd6, '1);
    write_reg(3'd7, '1);
    for (int i = 0; i < 30; i++) send_random_word(1'b0);
    drain();
  endtask

  // Random words under a run of configurations, most of them plausible cameras.
  task automatic test_random(int n_phases, int per_phase);
    for (int p = 0; p < n_phases; p++) begin
      quiet_mode = ($urandom_range(0, 3) == 0);
      if (p % 4 == 3)
        write_all({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                  48'({$urandom, $urandom}), 48'({$urandom, $urandom}));
      else
        camera_setup($urandom_range(100, 4000), $urandom_range(0, 3000));
      for (int i = 0; i < per_phase; i++) send_random_word(p % 4 != 3);
      drain();
    end
    quiet_mode = 1'b0;
  endtask

  // The receiver holds off for a long stretch while words keep coming.
  task automatic test_backpressure();
    camera_setup(800, 1000);
    hold_req = 400;
    for (int i = 0; i < 120; i++)
      send_word(ACT_PROJ, 16'($urandom), 16'($urandom), 16'($urandom_range(500, 20000)),
                0, 0, 0, 0, 1'b1);
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tuser = '0;
    in_tdata = '0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    out_tready = 1'b0;
    fail_cnt = 0;
    words_sent = 0;
    words_checked = 0;
    behind_cnt = 0;
    hit_cnt = 0;
    cycle_cnt = 0;
    quiet_mode = 1'b0;
    hold_req = 0;
    sh_rot_x = '0;
    sh_rot_y = '0;
    sh_rot_z = '0;
    sh_focal = '0;
    sh_centre = '0;
    sh_box_count = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_register_extremes();
    test_backpressure();
    test_random(20, 95);
    drain();

    $display("Sent %0d words and checked %0d results (%0d behind camera, %0d with box hits).",
             words_sent, words_checked, behind_cnt, hit_cnt);
    if (fail_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
